### hdl/nbq_pkg.sv
package nbq_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W  = 12;
  localparam int COEF_W    = 16;
  localparam int SHIFT_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = SAMPLE_W + 1 + COEF_W;
  localparam int ACC_W     = 33;
  localparam int NUM_FF    = 3;
  localparam int NUM_FB    = 2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'((1 << SAMPLE_W) - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_COEF_0  = 3'd0,
    REG_FF_COEF_1  = 3'd1,
    REG_FF_COEF_2  = 3'd2,
    REG_FB_COEF_1  = 3'd3,
    REG_FB_COEF_2  = 3'd4,
    REG_FRAC_SHIFT = 3'd5
  } reg_idx_t;

  typedef logic [COEF_W-1:0] coef_t;

  // Current filter settings
  typedef struct packed {
    coef_t [NUM_FF-1:0]  ff_coef;
    coef_t [NUM_FB-1:0]  fb_coef;
    logic [SHIFT_W-1:0]  frac_shift;
  } cfg_t;

  // Item handed from the feedforward stage to the feedback stage
  typedef struct packed {
    logic                    valid;
    logic                    start;
    logic signed [ACC_W-1:0] ff_sum;
  } ff_stage_t;

endpackage

### hdl/nbq_cfg.sv
module nbq_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nbq_pkg::COEF_W-1:0]    cfg_data,
  output nbq_pkg::cfg_t                 cfg
);

  nbq_pkg::cfg_t cfg_r;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ff_coef[0]  <= nbq_pkg::coef_t'(16'd4096);
      cfg_r.ff_coef[1]  <= '0;
      cfg_r.ff_coef[2]  <= '0;
      cfg_r.fb_coef[0]  <= '0;
      cfg_r.fb_coef[1]  <= '0;
      cfg_r.frac_shift  <= nbq_pkg::SHIFT_W'(12);
    end else if (cfg_valid) begin
      unique case (nbq_pkg::reg_idx_t'(cfg_index))
        nbq_pkg::REG_FF_COEF_0:  cfg_r.ff_coef[0] <= cfg_data;
        nbq_pkg::REG_FF_COEF_1:  cfg_r.ff_coef[1] <= cfg_data;
        nbq_pkg::REG_FF_COEF_2:  cfg_r.ff_coef[2] <= cfg_data;
        nbq_pkg::REG_FB_COEF_1:  cfg_r.fb_coef[0] <= cfg_data;
        nbq_pkg::REG_FB_COEF_2:  cfg_r.fb_coef[1] <= cfg_data;
        nbq_pkg::REG_FRAC_SHIFT: cfg_r.frac_shift <= cfg_data[nbq_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/nbq_ff.sv
module nbq_ff #(
  parameter int FF_TAPS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [nbq_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         in_start_req,
  input  nbq_pkg::cfg_t                cfg,
  input  logic                         take,
  output nbq_pkg::ff_stage_t           stage
);

  logic [nbq_pkg::SAMPLE_W-1:0]     xh_r [nbq_pkg::NUM_FF-1];
  logic [nbq_pkg::SAMPLE_W-1:0]     tap  [nbq_pkg::NUM_FF];
  logic signed [nbq_pkg::PROD_W-1:0] prod [nbq_pkg::NUM_FF];
  logic signed [nbq_pkg::ACC_W-1:0]  sum;
  nbq_pkg::ff_stage_t               stage_r;
  logic                             accept;

  assign in_ready = !stage_r.valid || take;
  assign accept   = in_valid && in_ready;
  assign stage    = stage_r;

  // Taps over the current sample and the input history; a start item sees zero history.
  always_comb begin
    tap[0] = in_sample;
    for (int j = 1; j < nbq_pkg::NUM_FF; j++) begin
      tap[j] = in_start_req ? '0 : xh_r[j-1];
    end
    sum = '0;
    for (int j = 0; j < nbq_pkg::NUM_FF; j++) begin
      prod[j] = $signed({1'b0, tap[j]}) * $signed(cfg.ff_coef[j]);
      if (j < FF_TAPS) begin
        sum = sum + nbq_pkg::ACC_W'(prod[j]);
      end
    end
  end

  // Stage register and item valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (accept) begin
      stage_r.valid <= 1'b1;
    end else if (take) begin
      stage_r.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r.start  <= in_start_req;
      stage_r.ff_sum <= sum;
    end
  end

  // Input history shifts on every accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < nbq_pkg::NUM_FF - 1; j++) begin
        xh_r[j] <= '0;
      end
    end else if (accept) begin
      xh_r[0] <= in_sample;
      for (int j = 1; j < nbq_pkg::NUM_FF - 1; j++) begin
        xh_r[j] <= tap[j];
      end
    end
  end

endmodule

### hdl/nbq_fb.sv
module nbq_fb #(
  parameter int FB_TAPS = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nbq_pkg::ff_stage_t           stage,
  input  nbq_pkg::cfg_t                cfg,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nbq_pkg::SAMPLE_W-1:0] out_filtered
);

  logic [nbq_pkg::SAMPLE_W-1:0]      yh_r [nbq_pkg::NUM_FB];
  logic [nbq_pkg::SAMPLE_W-1:0]      yh   [nbq_pkg::NUM_FB];
  logic signed [nbq_pkg::PROD_W-1:0] prod [nbq_pkg::NUM_FB];
  logic signed [nbq_pkg::ACC_W-1:0]  acc;
  logic signed [nbq_pkg::ACC_W-1:0]  rnd;
  logic signed [nbq_pkg::ACC_W-1:0]  shifted;
  logic [nbq_pkg::SAMPLE_W-1:0]      y_nxt;
  logic                              out_valid_r;
  logic [nbq_pkg::SAMPLE_W-1:0]      out_filtered_r;

  assign take         = stage.valid && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  // Feedback terms, rounding, arithmetic shift and clamp to the sample range.
  always_comb begin
    acc = stage.ff_sum;
    for (int j = 0; j < nbq_pkg::NUM_FB; j++) begin
      yh[j]   = stage.start ? '0 : yh_r[j];
      prod[j] = $signed({1'b0, yh[j]}) * $signed(cfg.fb_coef[j]);
      if (j < FB_TAPS) begin
        acc = acc - nbq_pkg::ACC_W'(prod[j]);
      end
    end
    if (cfg.frac_shift != '0) begin
      rnd = nbq_pkg::ACC_W'(1) <<< (cfg.frac_shift - nbq_pkg::SHIFT_W'(1));
    end else begin
      rnd = '0;
    end
    shifted = (acc + rnd) >>> cfg.frac_shift;
    if (shifted < 0) begin
      y_nxt = '0;
    end else if (shifted > nbq_pkg::ACC_W'(nbq_pkg::SAMPLE_MAX)) begin
      y_nxt = nbq_pkg::SAMPLE_MAX;
    end else begin
      y_nxt = shifted[nbq_pkg::SAMPLE_W-1:0];
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_filtered_r <= y_nxt;
    end
  end

  // Output history holds the clamped results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < nbq_pkg::NUM_FB; j++) begin
        yh_r[j] <= '0;
      end
    end else if (take) begin
      yh_r[0] <= y_nxt;
      for (int j = 1; j < nbq_pkg::NUM_FB; j++) begin
        yh_r[j] <= yh[j-1];
      end
    end
  end

endmodule

### hdl/fixed_point_notch_biquad_top.sv
// Direct-form-1 IIR notch biquad on a 12-bit unsigned sample stream, one
// filtered sample per input item. The block takes one item per clock cycle
// while the output is not stalled; out_valid rises once the item has passed
// through a stage register and then an output register. The first stage
// registers the feedforward sum of three 12x16 products; the second stage
// subtracts the two feedback products over the stored outputs, rounds,
// shifts by frac_shift and clamps to 0..4095, so that this output feedback
// loop sets the rate. An item with start_req set sees zero input and output
// history. Registers are to be written through the cfg port only while no
// item is in flight; the user is bound by this, as the block does not enforce it.
module fixed_point_notch_biquad_top #(
  parameter int FF_TAPS = 3,
  parameter int FB_TAPS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nbq_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          in_start_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nbq_pkg::SAMPLE_W-1:0]  out_filtered,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nbq_pkg::COEF_W-1:0]    cfg_data
);

  nbq_pkg::cfg_t      cfg;
  nbq_pkg::ff_stage_t stage;
  logic               take;

  nbq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nbq_ff #(
    .FF_TAPS (FF_TAPS)
  ) u_ff (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .in_start_req (in_start_req),
    .cfg          (cfg),
    .take         (take),
    .stage        (stage)
  );

  nbq_fb #(
    .FB_TAPS (FB_TAPS)
  ) u_fb (
    .clk          (clk),
    .rst_n        (rst_n),
    .stage        (stage),
    .cfg          (cfg),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered)
  );

  // An accepted item always lands in the first stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> stage.valid)
    else $error("accepted item missing from first stage");

  // A staged item that is not moved on stays in place.
  assert property (@(posedge clk) disable iff (!rst_n)
    (stage.valid && !take) |=> (stage.valid && $stable(stage.ff_sum)))
    else $error("staged item lost while output stalled");

  // Moving an item into the output register makes a result visible.
  assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("result not presented after stage advance");

  // Nothing advances into a full output register that is not being drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !take)
    else $error("output register overwritten");

endmodule
